@@ sv/rrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// shared types and codes for the ranging responder sequencer
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 40;

  // status read that failed on the bus
  localparam logic [31:0] STATUS_BAD = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TX_DONE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_DONE_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RX_FAIL_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_CODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_CODE   = 3'd5;

  // request kinds
  localparam logic ACT_IRQ     = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // radio commands
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_ENABLE_RX  = 3'd1;
  localparam logic [2:0] CMD_RESET_RX   = 3'd2;
  localparam logic [2:0] CMD_SEND_REPLY = 3'd3;
  localparam logic [2:0] CMD_SEND_TIMES = 3'd4;

  // phase codes
  localparam logic [1:0] PH_WAIT_RX    = 2'd0;
  localparam logic [1:0] PH_WAIT_REPLY = 2'd1;
  localparam logic [1:0] PH_WAIT_TIMES = 2'd2;

  typedef struct packed {
    logic [31:0] tx_done_mask;
    logic [31:0] rx_done_mask;
    logic [31:0] rx_fail_mask;
    logic [7:0]  first_code;
    logic [7:0]  second_code;
    logic [7:0]  reply_code;
  } cfg_t;

  typedef struct packed {
    logic        tx_hit;
    logic        rx_hit;
    logic        err_hit;
    logic [31:0] ack;
  } decode_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       tx_pending;
    logic       rx_pending;
    logic       err_pending;
    logic       flag_first;
    logic       flag_second;
  } ctrl_t;

endpackage

@@ sv/rrs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_in_if / rrs_out_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface rrs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] status_word;
  logic [7:0]  frame_type;
  logic [39:0] rx_stamp;
  logic [39:0] tx_stamp;

  modport source (output valid, action, status_word, frame_type, rx_stamp, tx_stamp,
                  input ready);
  modport sink   (input valid, action, status_word, frame_type, rx_stamp, tx_stamp,
                  output ready);
endinterface

interface rrs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] ack_bits;
  logic [7:0]  reply_byte;
  logic [39:0] poll_rx_time;
  logic [39:0] resp_tx_time;
  logic [39:0] final_rx_time;
  logic        seen_first;
  logic        seen_second;
  logic [1:0]  phase_out;

  modport source (output valid, command, ack_bits, reply_byte, poll_rx_time, resp_tx_time,
                  final_rx_time, seen_first, seen_second, phase_out,
                  input ready);
  modport sink   (input valid, command, ack_bits, reply_byte, poll_rx_time, resp_tx_time,
                  final_rx_time, seen_first, seen_second, phase_out,
                  output ready);
endinterface

@@ sv/ranging_responder_sequencer.sv @@
`timescale 1ns / 1ps
// path: an accepted request is held in the input register and loads the result
//   register once that register is free or drains (one input register, one result register)
// throughput: one request per cycle while results drain; a single pass of decode
//   plus phase logic updates the state between the input and result registers
// reset: synchronous, active high; clears phase, pending and sticky flags, stored
//   times and both pipeline valids, and loads the mask and code defaults
// ----------------------------------------------------------------------------
// ranging_responder_sequencer
// responder side of a double-sided two-way ranging exchange
// ----------------------------------------------------------------------------
module ranging_responder_sequencer
  import rrs_pkg::*;
#(
  parameter int STAMP_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rrs_in_if.sink                req,
  rrs_out_if.source             rsp
);

  // configuration registers
  cfg_t cfg;

  // input register
  logic        s1_valid;
  logic        s1_action;
  logic [31:0] s1_status;
  logic [7:0]  s1_frame_type;
  logic [39:0] s1_rx_stamp;
  logic [39:0] s1_tx_stamp;

  // sequencer state
  ctrl_t                 ctrl;
  logic [7:0]            held_type;
  logic [STAMP_BITS-1:0] held_rx_time;
  logic [STAMP_BITS-1:0] held_tx_time;
  logic [STAMP_BITS-1:0] poll_time;
  logic [STAMP_BITS-1:0] reply_time;
  logic [STAMP_BITS-1:0] final_time;

  // next values from the single-pass logic
  decode_t               dec;
  ctrl_t                 ctrl_next;
  logic [7:0]            held_type_next;
  logic [STAMP_BITS-1:0] held_rx_time_next;
  logic [STAMP_BITS-1:0] held_tx_time_next;
  logic [STAMP_BITS-1:0] poll_time_next;
  logic [STAMP_BITS-1:0] reply_time_next;
  logic [STAMP_BITS-1:0] final_time_next;
  logic [2:0]            command_next;
  logic [7:0]            reply_byte_next;

  // stored times widened so any stamp width maps onto the 40-bit result fields
  logic [63:0] poll_wide;
  logic [63:0] reply_wide;
  logic [63:0] final_wide;

  logic req_take;
  logic advance;

  // the input register moves on whenever the result register is free or drains
  assign advance  = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign req_take = req.valid && req.ready;

  // ---------------------------------------------------------------------------
  // configuration writes; the host must issue them only while idle, the block does not enforce it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tx_done_mask <= 32'd128;
      cfg.rx_done_mask <= 32'd24576;
      cfg.rx_fail_mask <= 32'd69718016;
      cfg.first_code   <= 8'd1;
      cfg.second_code  <= 8'd2;
      cfg.reply_code   <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TX_DONE_MASK: cfg.tx_done_mask <= cfg_data;
        REG_RX_DONE_MASK: cfg.rx_done_mask <= cfg_data;
        REG_RX_FAIL_MASK: cfg.rx_fail_mask <= cfg_data;
        REG_FIRST_CODE:   cfg.first_code   <= cfg_data[7:0];
        REG_SECOND_CODE:  cfg.second_code  <= cfg_data[7:0];
        REG_REPLY_CODE:   cfg.reply_code   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_action     <= req.action;
      s1_status     <= req.status_word;
      s1_frame_type <= req.frame_type;
      s1_rx_stamp   <= req.rx_stamp;
      s1_tx_stamp   <= req.tx_stamp;
    end
  end

  // ---------------------------------------------------------------------------
  // single pass: status decode, then the phase machine
  // ---------------------------------------------------------------------------
  rrs_decode u_decode (
    .action      (s1_action),
    .status_word (s1_status),
    .cfg         (cfg),
    .dec         (dec)
  );

  rrs_step #(
    .STAMP_BITS (STAMP_BITS)
  ) u_step (
    .action            (s1_action),
    .frame_type        (s1_frame_type),
    .rx_stamp          (s1_rx_stamp),
    .tx_stamp          (s1_tx_stamp),
    .dec               (dec),
    .cfg               (cfg),
    .ctrl              (ctrl),
    .held_type         (held_type),
    .held_rx_time      (held_rx_time),
    .held_tx_time      (held_tx_time),
    .poll_time         (poll_time),
    .reply_time        (reply_time),
    .final_time        (final_time),
    .ctrl_next         (ctrl_next),
    .held_type_next    (held_type_next),
    .held_rx_time_next (held_rx_time_next),
    .held_tx_time_next (held_tx_time_next),
    .poll_time_next    (poll_time_next),
    .reply_time_next   (reply_time_next),
    .final_time_next   (final_time_next),
    .command           (command_next),
    .reply_byte        (reply_byte_next)
  );

  // ---------------------------------------------------------------------------
  // state commits when a request passes into the result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl         <= '0;
      held_type    <= 8'd0;
      held_rx_time <= '0;
      held_tx_time <= '0;
      poll_time    <= '0;
      reply_time   <= '0;
      final_time   <= '0;
    end else if (advance) begin
      ctrl         <= ctrl_next;
      held_type    <= held_type_next;
      held_rx_time <= held_rx_time_next;
      held_tx_time <= held_tx_time_next;
      poll_time    <= poll_time_next;
      reply_time   <= reply_time_next;
      final_time   <= final_time_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  assign poll_wide  = 64'(poll_time_next);
  assign reply_wide = 64'(reply_time_next);
  assign final_wide = 64'(final_time_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.command       <= command_next;
      rsp.ack_bits      <= dec.ack;
      rsp.reply_byte    <= reply_byte_next;
      rsp.poll_rx_time  <= poll_wide[TIME_W-1:0];
      rsp.resp_tx_time  <= reply_wide[TIME_W-1:0];
      rsp.final_rx_time <= final_wide[TIME_W-1:0];
      rsp.seen_first    <= ctrl_next.flag_first;
      rsp.seen_second   <= ctrl_next.flag_second;
      rsp.phase_out     <= ctrl_next.phase;
    end
  end

endmodule

@@ sv/rrs_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_decode
// status word decode through the three masks, acknowledge mask
// ----------------------------------------------------------------------------
module rrs_decode
  import rrs_pkg::*;
(
  input  logic        action,
  input  logic [31:0] status_word,
  input  cfg_t        cfg,
  output decode_t     dec
);

  logic good_read;

  assign good_read = (action == ACT_IRQ) && (status_word != STATUS_BAD);

  always_comb begin
    dec.tx_hit  = good_read && ((status_word & cfg.tx_done_mask) != 32'd0);
    dec.rx_hit  = good_read && ((status_word & cfg.rx_done_mask) == cfg.rx_done_mask);
    dec.err_hit = good_read && ((status_word & cfg.rx_fail_mask) != 32'd0);
    dec.ack     = (dec.tx_hit  ? cfg.tx_done_mask : 32'd0)
                | (dec.rx_hit  ? cfg.rx_done_mask : 32'd0)
                | (dec.err_hit ? cfg.rx_fail_mask : 32'd0);
  end

endmodule

@@ sv/rrs_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_step
// phase machine next state, stored times and command for one request
// ----------------------------------------------------------------------------
module rrs_step
  import rrs_pkg::*;
#(
  parameter int STAMP_BITS = 40
) (
  input  logic                  action,
  input  logic [7:0]            frame_type,
  input  logic [39:0]           rx_stamp,
  input  logic [39:0]           tx_stamp,
  input  decode_t               dec,
  input  cfg_t                  cfg,
  input  ctrl_t                 ctrl,
  input  logic [7:0]            held_type,
  input  logic [STAMP_BITS-1:0] held_rx_time,
  input  logic [STAMP_BITS-1:0] held_tx_time,
  input  logic [STAMP_BITS-1:0] poll_time,
  input  logic [STAMP_BITS-1:0] reply_time,
  input  logic [STAMP_BITS-1:0] final_time,
  output ctrl_t                 ctrl_next,
  output logic [7:0]            held_type_next,
  output logic [STAMP_BITS-1:0] held_rx_time_next,
  output logic [STAMP_BITS-1:0] held_tx_time_next,
  output logic [STAMP_BITS-1:0] poll_time_next,
  output logic [STAMP_BITS-1:0] reply_time_next,
  output logic [STAMP_BITS-1:0] final_time_next,
  output logic [2:0]            command,
  output logic [7:0]            reply_byte
);

  logic [63:0] rx_wide;
  logic [63:0] tx_wide;

  assign rx_wide = 64'(rx_stamp);
  assign tx_wide = 64'(tx_stamp);

  always_comb begin
    ctrl_next         = ctrl;
    held_type_next    = held_type;
    held_rx_time_next = held_rx_time;
    held_tx_time_next = held_tx_time;
    poll_time_next    = poll_time;
    reply_time_next   = reply_time;
    final_time_next   = final_time;
    command           = CMD_NONE;
    reply_byte        = 8'd0;

    if (action == ACT_RESTART) begin
      // error flag survives a restart
      ctrl_next.tx_pending = 1'b0;
      ctrl_next.rx_pending = 1'b0;
      ctrl_next.phase      = PH_WAIT_RX;
      command              = CMD_ENABLE_RX;
    end else begin
      if (dec.tx_hit) begin
        ctrl_next.tx_pending = 1'b1;
        held_tx_time_next    = tx_wide[STAMP_BITS-1:0];
      end
      if (dec.rx_hit) begin
        ctrl_next.rx_pending = 1'b1;
        held_type_next       = frame_type;
        held_rx_time_next    = rx_wide[STAMP_BITS-1:0];
      end
      if (dec.err_hit) begin
        ctrl_next.err_pending = 1'b1;
      end

      case (ctrl.phase)
        PH_WAIT_REPLY: begin
          if (ctrl_next.tx_pending) begin
            reply_time_next      = held_tx_time_next;
            ctrl_next.tx_pending = 1'b0;
            ctrl_next.phase      = PH_WAIT_RX;
            command              = CMD_ENABLE_RX;
          end
        end
        PH_WAIT_TIMES: begin
          if (ctrl_next.tx_pending) begin
            ctrl_next.tx_pending = 1'b0;
            ctrl_next.rx_pending = 1'b0;
            ctrl_next.phase      = PH_WAIT_RX;
            command              = CMD_ENABLE_RX;
          end
        end
        default: begin
          ctrl_next.phase = PH_WAIT_RX;
          if (ctrl_next.err_pending) begin
            ctrl_next.err_pending = 1'b0;
            ctrl_next.tx_pending  = 1'b0;
            ctrl_next.rx_pending  = 1'b0;
            command               = CMD_RESET_RX;
          end else if (ctrl_next.rx_pending) begin
            ctrl_next.rx_pending = 1'b0;
            ctrl_next.tx_pending = 1'b0;
            if (held_type_next == cfg.first_code) begin
              poll_time_next       = held_rx_time_next;
              ctrl_next.flag_first = 1'b1;
              reply_byte           = cfg.reply_code;
              ctrl_next.phase      = PH_WAIT_REPLY;
              command              = CMD_SEND_REPLY;
            end else if (held_type_next == cfg.second_code) begin
              final_time_next       = held_rx_time_next;
              ctrl_next.flag_second = 1'b1;
              ctrl_next.phase       = PH_WAIT_TIMES;
              command               = CMD_SEND_TIMES;
            end else begin
              command = CMD_ENABLE_RX;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ sv/rrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module rrs_checker
  import rrs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] command,
  input logic [7:0] reply_byte,
  input logic       seen_first,
  input logic       seen_second,
  input logic [1:0] phase_out
);

  // a stalled result is not dropped
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a reply goes out only together with the move to waiting for its send
  a_reply_phase: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && command == CMD_SEND_REPLY |-> phase_out == PH_WAIT_REPLY && seen_first)
    else $error("reply command without reply phase");

  a_times_phase: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && command == CMD_SEND_TIMES |-> phase_out == PH_WAIT_TIMES && seen_second)
    else $error("times command without times phase");

  // receive commands always leave the sequencer waiting for a frame
  a_rx_phase: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (command == CMD_ENABLE_RX || command == CMD_RESET_RX)
      |-> phase_out == PH_WAIT_RX)
    else $error("receive command outside waiting receive");

  a_reply_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && command != CMD_SEND_REPLY |-> reply_byte == 8'd0)
    else $error("reply byte set without reply command");

endmodule

bind ranging_responder_sequencer rrs_checker u_rrs_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .command     (rsp.command),
  .reply_byte  (rsp.reply_byte),
  .seen_first  (rsp.seen_first),
  .seen_second (rsp.seen_second),
  .phase_out   (rsp.phase_out)
);
